// ===== sv/vnsl_pkg.sv =====
// Shared types and constants for the nearest-seed labeler.
// Used by vnsl_ctrl, vnsl_datapath and voronoi_nearest_seed_labeler.
package vnsl_pkg;

  localparam int DEF_MAX_SEEDS = 64;

  localparam int MODE_W   = 2;
  localparam int COORD_W  = 10;
  localparam int LABEL_W  = 8;
  localparam int STATUS_W = 3;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int HELD_W   = 7;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ANSWERED = 3'd0,
    ST_STORED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_CLEARED  = 3'd4
  } vnsl_status_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the accepted item
    logic exec;     // clear, store, or set up a query sweep
    logic issue;    // read one table entry into the compare pipeline
    logic emit;     // load the output register
  } vnsl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_sweep;
    logic last_addr;
    logic pipe_busy;
    logic out_free;
  } vnsl_sts_t;

endpackage

// ===== sv/vnsl_ctrl.sv =====
// Sequencer for the nearest-seed labeler: accept, execute, sweep, drain, emit.
// Depends on vnsl_pkg.
module vnsl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vnsl_pkg::vnsl_sts_t sts,
  output vnsl_pkg::vnsl_cmd_t cmd
);
  import vnsl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_sweep ? S_SWEEP : S_DONE;
      end
      S_SWEEP: begin
        cmd.issue = 1'b1;
        if (sts.last_addr) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/vnsl_datapath.sv =====
// Datapath of the nearest-seed labeler: seed table, distance pipeline,
// running minimum and output register. Depends on vnsl_pkg.
module vnsl_datapath #(
  parameter int MAX_SEEDS = vnsl_pkg::DEF_MAX_SEEDS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vnsl_pkg::vnsl_cmd_t               cmd,
  output vnsl_pkg::vnsl_sts_t               sts,
  input  logic [vnsl_pkg::MODE_W-1:0]       in_mode,
  input  logic [vnsl_pkg::COORD_W-1:0]      in_coord_x,
  input  logic [vnsl_pkg::COORD_W-1:0]      in_coord_y,
  input  logic [vnsl_pkg::LABEL_W-1:0]      in_seed_label,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vnsl_pkg::STATUS_W-1:0]     out_status,
  output logic [vnsl_pkg::LABEL_W-1:0]      out_region_label,
  output logic [vnsl_pkg::DIST_W-1:0]       out_distance_sq,
  output logic [vnsl_pkg::HELD_W-1:0]       out_seeds_held
);
  import vnsl_pkg::*;

  localparam int AW    = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CNT_W = $clog2(MAX_SEEDS + 1);

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [LABEL_W-1:0] region;
  } seed_t;

  seed_t seed_mem [MAX_SEEDS];

  // captured item
  logic [MODE_W-1:0]  mode_r;
  logic [COORD_W-1:0] cx_r, cy_r;
  logic [LABEL_W-1:0] lab_r;

  logic [CNT_W-1:0]   total_r;
  vnsl_status_t       res_r;
  logic [AW-1:0]      rd_addr_r;

  // compare pipeline
  seed_t              rd_data_r;
  logic               v1_r, v2_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r;
  logic [LABEL_W-1:0] lab2_r;
  logic               have_r;
  logic [DIST_W-1:0]  best_r;
  logic [LABEL_W-1:0] best_lab_r;

  logic               out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [LABEL_W-1:0] out_label_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic [HELD_W-1:0]  out_held_r;

  logic               is_query, is_full;
  logic [COORD_W-1:0] dx, dy;
  logic [DIST_W-1:0]  sum_sq;

  assign is_query = mode_r[MODE_W-1];  // mode 3 also queries
  assign is_full  = (total_r >= CNT_W'(MAX_SEEDS));

  assign dx     = (cx_r >= rd_data_r.col) ? cx_r - rd_data_r.col : rd_data_r.col - cx_r;
  assign dy     = (cy_r >= rd_data_r.row) ? cy_r - rd_data_r.row : rd_data_r.row - cy_r;
  assign sum_sq = DIST_W'(sqx_r) + DIST_W'(sqy_r);

  assign sts.need_sweep = is_query && (total_r != '0);
  assign sts.last_addr  = (rd_addr_r == '0);
  assign sts.pipe_busy  = v1_r | v2_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && mode_r == MODE_LOAD && !is_full) begin
      seed_mem[total_r[AW-1:0]] <= '{col: cx_r, row: cy_r, region: lab_r};
    end
    if (cmd.issue) begin
      rd_data_r <= seed_mem[rd_addr_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      cx_r   <= in_coord_x;
      cy_r   <= in_coord_y;
      lab_r  <= in_seed_label;
    end
    if (cmd.exec) begin
      rd_addr_r <= AW'(total_r - 1'b1);
    end else if (cmd.issue) begin
      rd_addr_r <= rd_addr_r - 1'b1;
    end
    if (v1_r) begin
      sqx_r  <= SQ_W'(dx) * SQ_W'(dx);
      sqy_r  <= SQ_W'(dy) * SQ_W'(dy);
      lab2_r <= rd_data_r.region;
    end
    // newest seed comes first; strict compare keeps it on ties
    if (v2_r && (!have_r || sum_sq < best_r)) begin
      best_r     <= sum_sq;
      best_lab_r <= lab2_r;
    end
    if (cmd.emit) begin
      out_status_r <= res_r;
      out_label_r  <= (res_r == ST_ANSWERED) ? best_lab_r : '0;
      out_dist_r   <= (res_r == ST_ANSWERED) ? best_r : '0;
      out_held_r   <= HELD_W'(total_r);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      res_r       <= ST_CLEARED;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.exec) begin
        have_r <= 1'b0;
        if (is_query) begin
          res_r <= (total_r == '0) ? ST_EMPTY : ST_ANSWERED;
        end else if (mode_r == MODE_CLEAR) begin
          total_r <= '0;
          res_r   <= ST_CLEARED;
        end else if (is_full) begin
          res_r <= ST_FULL;
        end else begin
          total_r <= total_r + 1'b1;
          res_r   <= ST_STORED;
        end
      end else if (v2_r) begin
        have_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_region_label = out_label_r;
  assign out_distance_sq  = out_dist_r;
  assign out_seeds_held   = out_held_r;

endmodule

// ===== sv/voronoi_nearest_seed_labeler.sv =====
// Nearest-seed labeler: keeps up to MAX_SEEDS seeds (column, row, label) and
// answers each item with one result. Clear and load items are accepted, then
// executed and emitted to the output register. A query sweeps all seeds held:
// the table has one read port, so the sweep reads one seed per cycle, newest
// first, through a three-stage pipeline (read, square, sum and compare); on
// equal distance the newest seed wins. The block takes one item at a time
// and accepts the next one while the previous result waits in the output
// register. Depends on vnsl_pkg, vnsl_ctrl and vnsl_datapath.
module voronoi_nearest_seed_labeler #(
  parameter int MAX_SEEDS = vnsl_pkg::DEF_MAX_SEEDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vnsl_pkg::MODE_W-1:0]   in_mode,
  input  logic [vnsl_pkg::COORD_W-1:0]  in_coord_x,
  input  logic [vnsl_pkg::COORD_W-1:0]  in_coord_y,
  input  logic [vnsl_pkg::LABEL_W-1:0]  in_seed_label,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vnsl_pkg::STATUS_W-1:0] out_status,
  output logic [vnsl_pkg::LABEL_W-1:0]  out_region_label,
  output logic [vnsl_pkg::DIST_W-1:0]   out_distance_sq,
  output logic [vnsl_pkg::HELD_W-1:0]   out_seeds_held
);
  import vnsl_pkg::*;

  vnsl_cmd_t cmd;
  vnsl_sts_t sts;

  vnsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vnsl_datapath #(
    .MAX_SEEDS (MAX_SEEDS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_seed_label    (in_seed_label),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_region_label (out_region_label),
    .out_distance_sq  (out_distance_sq),
    .out_seeds_held   (out_seeds_held)
  );

endmodule

// ===== test/tb_voronoi_nearest_seed_labeler.sv =====
// Testbench for voronoi_nearest_seed_labeler: directed and random clear, load and query
// items go through a queue-fed driver; a monitor checks each result against an inline predictor.
// Depends on vnsl_pkg and the labeler RTL.
module tb_voronoi_nearest_seed_labeler;
  import vnsl_pkg::*;

  localparam int SEED_CAP = DEF_MAX_SEEDS;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CALM_TAIL = 150;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // decodes as a query

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LABEL_W-1:0] label;
    logic               drain;  // sender holds until all results are back
  } seed_item_t;

  typedef struct packed {
    vnsl_status_t       status;
    logic [LABEL_W-1:0] label;
    logic [DIST_W-1:0]  dist_sq;
    logic [HELD_W-1:0]  held;
  } seed_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] in_mode = '0;
  logic [COORD_W-1:0] in_coord_x = '0;
  logic [COORD_W-1:0] in_coord_y = '0;
  logic [LABEL_W-1:0] in_seed_label = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [LABEL_W-1:0] out_region_label;
  logic [DIST_W-1:0] out_distance_sq;
  logic [HELD_W-1:0] out_seeds_held;

  voronoi_nearest_seed_labeler u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_seed_label    (in_seed_label),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_region_label (out_region_label),
    .out_distance_sq  (out_distance_sq),
    .out_seeds_held   (out_seeds_held)
  );

  seed_item_t   pending_items[$];
  seed_result_t awaited_results[$];
  int errors = 0;
  int accepted_cnt = 0;
  int item_total = 0;
  int n_answered = 0, n_stored = 0, n_dropped = 0, n_empty = 0, n_cleared = 0;
  logic hold_next = 1'b0;

  // predictor's own copy of the seed table
  logic [COORD_W-1:0] tbl_col[SEED_CAP];
  logic [COORD_W-1:0] tbl_row[SEED_CAP];
  logic [LABEL_W-1:0] tbl_label[SEED_CAP];
  int tbl_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic seed_result_t nearest_seed_result(input seed_item_t it);
    seed_result_t r;
    int unsigned dx, dy, d, best;
    logic [LABEL_W-1:0] best_label;
    r.status = ST_ANSWERED;
    r.label = '0;
    r.dist_sq = '0;
    if (it.mode == MODE_CLEAR) begin
      tbl_count = 0;
      r.status = ST_CLEARED;
    end else if (it.mode == MODE_LOAD) begin
      if (tbl_count < SEED_CAP) begin
        tbl_col[tbl_count] = it.x;
        tbl_row[tbl_count] = it.y;
        tbl_label[tbl_count] = it.label;
        tbl_count++;
        r.status = ST_STORED;
      end else begin
        r.status = ST_FULL;
      end
    end else if (tbl_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      best = 0;
      best_label = '0;
      // newest first; strict less-than keeps the newest on a tie
      for (int k = tbl_count - 1; k >= 0; k--) begin
        dx = (it.x >= tbl_col[k]) ? it.x - tbl_col[k] : tbl_col[k] - it.x;
        dy = (it.y >= tbl_row[k]) ? it.y - tbl_row[k] : tbl_row[k] - it.y;
        d = dx * dx + dy * dy;
        if (k == tbl_count - 1 || d < best) begin
          best = d;
          best_label = tbl_label[k];
        end
      end
      r.label = best_label;
      r.dist_sq = DIST_W'(best);
    end
    r.held = HELD_W'(tbl_count);
    return r;
  endfunction

  function automatic void push_item(input logic [MODE_W-1:0] m, input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y, input logic [LABEL_W-1:0] lab);
    seed_item_t it;
    it.mode = m;
    it.x = x;
    it.y = y;
    it.label = lab;
    it.drain = hold_next;
    hold_next = 1'b0;
    pending_items.push_back(it);
  endfunction

  function automatic logic idling_allowed();
    if (accepted_cnt >= item_total - CALM_TAIL) return 1'b0;
    return ((accepted_cnt / 128) % 4) != 1;  // no idle gaps or stalls in every fourth stretch of 128 items
  endfunction

  // stimulus
  initial begin : fill_items
    int directed_cnt, seq_no, n_seeds, n_queries, pick, idx;
    logic cluster;
    logic [COORD_W-1:0] lx[$], ly[$];
    logic [COORD_W-1:0] qx, qy;
    logic [MODE_W-1:0] qm;

    push_item(MODE_QUERY, 10'd3, 10'd4, 8'd9);         // empty table
    push_item(MODE_CLEAR, 10'd0, 10'd0, 8'd0);
    push_item(MODE_LOAD, 10'd0, 10'd0, 8'd0);
    push_item(MODE_QUERY, 10'd1023, 10'd1023, 8'd255);  // largest distance
    push_item(MODE_LOAD, 10'd1023, 10'd1023, 8'd255);
    push_item(MODE_QUERY, 10'd0, 10'd0, 8'd0);
    push_item(MODE_SPARE, 10'd1023, 10'd0, 8'd0);       // spare mode, equidistant
    push_item(MODE_LOAD, 10'd512, 10'd512, 8'hAA);
    push_item(MODE_LOAD, 10'd512, 10'd512, 8'h55);      // same spot, newer wins
    push_item(MODE_QUERY, 10'd512, 10'd512, 8'd0);
    push_item(MODE_QUERY, 10'd510, 10'd514, 8'd0);
    push_item(MODE_LOAD, 10'h155, 10'h2AA, 8'h5A);
    push_item(MODE_LOAD, 10'h2AA, 10'h155, 8'hA5);
    push_item(MODE_QUERY, 10'd700, 10'd300, 8'hFF);
    push_item(MODE_SPARE, 10'd1, 10'd1022, 8'd0);
    hold_next = 1'b1;
    push_item(MODE_CLEAR, 10'd1023, 10'd1023, 8'd255);
    push_item(MODE_SPARE, 10'd0, 10'd0, 8'd0);          // empty after clear
    push_item(MODE_LOAD, 10'd5, 10'd5, 8'd1);
    push_item(MODE_QUERY, 10'd5, 10'd5, 8'd0);
    directed_cnt = pending_items.size();

    seq_no = 0;
    while (pending_items.size() < directed_cnt + RANDOM_ITEMS) begin
      seq_no++;
      if (seq_no % 10 == 0) hold_next = 1'b1;
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(1, 10))
          push_item(MODE_W'($urandom_range(0, 3)), COORD_W'($urandom), COORD_W'($urandom),
                    LABEL_W'($urandom));
      end else begin
        cluster = ($urandom_range(0, 2) == 0);
        n_seeds = (seq_no % 6 == 5) ? $urandom_range(60, 70) : $urandom_range(1, 10);
        n_queries = $urandom_range(2, 12);
        lx.delete();
        ly.delete();
        if ($urandom_range(0, 9) < 7)
          push_item(MODE_CLEAR, COORD_W'($urandom), COORD_W'($urandom), LABEL_W'($urandom));
        repeat (n_seeds) begin
          if (cluster) begin
            lx.push_back(COORD_W'(500 + $urandom_range(0, 6)));
            ly.push_back(COORD_W'(500 + $urandom_range(0, 6)));
          end else begin
            lx.push_back(COORD_W'($urandom));
            ly.push_back(COORD_W'($urandom));
          end
          push_item(MODE_LOAD, lx[$], ly[$], LABEL_W'($urandom));
        end
        repeat (n_queries) begin
          pick = $urandom_range(0, 2);
          if (pick == 1) begin
            idx = $urandom_range(0, lx.size() - 1);
            qx = lx[idx];
            qy = ly[idx];
          end else if (pick == 2) begin
            qx = COORD_W'(497 + $urandom_range(0, 12));
            qy = COORD_W'(497 + $urandom_range(0, 12));
          end else begin
            qx = COORD_W'($urandom);
            qy = COORD_W'($urandom);
          end
          qm = ($urandom_range(0, 5) == 0) ? MODE_SPARE : MODE_QUERY;
          push_item(qm, qx, qy, LABEL_W'($urandom));
        end
      end
    end
    item_total = pending_items.size();
  end

  // driver
  always @(posedge clk) begin : drive_items
    logic busy;
    seed_item_t it;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        it.mode = in_mode;
        it.x = in_coord_x;
        it.y = in_coord_y;
        it.label = in_seed_label;
        it.drain = 1'b0;
        awaited_results.push_back(nearest_seed_result(it));
        accepted_cnt++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && awaited_results.size() != 0)) begin
          it = pending_items.pop_front();
          in_mode <= it.mode;
          in_coord_x <= it.x;
          in_coord_y <= it.y;
          in_seed_label <= it.label;
          busy = 1'b1;
          if (idling_allowed() && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 16);
        end
      end
      in_valid <= busy;
    end
  end

  // monitor
  always @(posedge clk) begin : check_results
    seed_result_t want;
    int stall_left;
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none expected: status %0d label %0d dist %0d held %0d",
                   $time, out_status, out_region_label, out_distance_sq, out_seeds_held);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            errors++;
          end
          if (out_region_label !== want.label) begin
            $display("%0t: region_label expected %0d actual %0d", $time, want.label,
                     out_region_label);
            errors++;
          end
          if (out_distance_sq !== want.dist_sq) begin
            $display("%0t: distance_sq expected %0d actual %0d", $time, want.dist_sq,
                     out_distance_sq);
            errors++;
          end
          if (out_seeds_held !== want.held) begin
            $display("%0t: seeds_held expected %0d actual %0d", $time, want.held,
                     out_seeds_held);
            errors++;
          end
          case (want.status)
            ST_ANSWERED: n_answered++;
            ST_STORED:   n_stored++;
            ST_FULL:     n_dropped++;
            ST_EMPTY:    n_empty++;
            default:     n_cleared++;
          endcase
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (idling_allowed() && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
      end
      out_ready <= rdy;
    end
  end

  initial begin : finish_run
    wait (rst_n);
    while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Ran %0d items: %0d answered queries, %0d empty-table queries,", accepted_cnt,
             n_answered, n_empty);
    $display("  %0d seeds stored, %0d dropped on a full table, %0d clears", n_stored,
             n_dropped, n_cleared);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
